[hw/rtl/brf_pkg.sv]
// Shared types, field widths and operation codes for the byte ring FIFO.
// No dependencies; every other file of the block imports this package.

package brf_pkg;

   // Default sizing of the ring and of the longest slice
   localparam int DEF_MAX_DEPTH = 128;
   localparam int DEF_MAX_SLICE = 64;

   // Field widths
   localparam int FUNC_W   = 3;
   localparam int DATA_W   = 8;
   localparam int OFFSET_W = 7;
   localparam int LENGTH_W = 7;
   localparam int COUNT_W  = 7;
   localparam int SIZE_W   = 3;

   // Ring size register after reset
   localparam logic [SIZE_W-1:0] SIZE_RESET = 3'd7;

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_PUT   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_GET   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_COUNT = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_SLICE = 3'd4;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic put;         // store the request byte, advance write index
      logic get;         // advance read index
      logic clear;       // zero both indices
      logic rd_first;    // read store at read index (plus offset)
      logic use_offset;  // add the request offset to the first read
      logic rd_next;     // read store at the next slice position
      logic load;        // load the result register
      logic ok;
      logic has;
      logic last;
   } brf_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic full;
      logic empty;
      logic slice_ok;
   } brf_stat_type;

endpackage

[hw/rtl/brf_if.sv]
// Channel interfaces of the byte ring FIFO: request, result and size register.
// Depends on brf_pkg for field widths.

interface brf_req_if import brf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [DATA_W-1:0]   data_in;
   logic [OFFSET_W-1:0] offset;
   logic [LENGTH_W-1:0] length;

   modport source (output valid, func, data_in, offset, length, input ready);
   modport sink   (input valid, func, data_in, offset, length, output ready);
endinterface

interface brf_rsp_if import brf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               ok;
   logic [DATA_W-1:0]  data_out;
   logic               has_data;
   logic [COUNT_W-1:0] count;
   logic               last;

   modport source (output valid, ok, data_out, has_data, count, last, input ready);
   modport sink   (input valid, ok, data_out, has_data, count, last, output ready);
endinterface

interface brf_csr_if import brf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SIZE_W-1:0] wdata;

   modport source (output valid, wdata, input ready);
   modport sink   (input valid, wdata, output ready);
endinterface

[hw/rtl/byte_ring_fifo_with_peek.sv]
// Top level of the byte ring FIFO with slice peek.
// Depends on brf_pkg, brf_if, brf_controller and brf_datapath.
//
// A byte FIFO in a power-of-two ring (one slot kept empty) taking put, get,
// count, clear and slice-peek requests; each request gives one result, a
// slice gives one result per byte with last set on the final one. A request
// is taken in the idle state and its result is loaded into the output
// register from the emit state once that register is free; a slice loads
// one byte per cycle while the result register is free, fed by the single
// registered read port of the byte store. A new request is taken while the
// previous result still waits on the result channel. Writing the size
// register clears both indices; the store itself has no clearing pass and
// is ready right after reset.

module byte_ring_fifo_with_peek import brf_pkg::*; #(
   parameter int MAX_DEPTH = DEF_MAX_DEPTH,
   parameter int MAX_SLICE = DEF_MAX_SLICE
) (
   input  logic      clock,
   input  logic      reset,
   brf_req_if.sink   req_ch,
   brf_rsp_if.source rsp_ch,
   brf_csr_if.sink   csr_ch
);

   brf_cmd_type  cmd;
   brf_stat_type stat;
   logic         csr_wr;

   // The user must send size writes only while idle; the block does not enforce it. Always take them
   assign csr_ch.ready = 1'b1;
   assign csr_wr       = csr_ch.valid;

   brf_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .req_func   (req_ch.func),
      .req_length (req_ch.length),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   brf_datapath #(
      .MAX_DEPTH (MAX_DEPTH),
      .MAX_SLICE (MAX_SLICE)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .csr_wr   (csr_wr),
      .csr_data (csr_ch.wdata),
      .data_in  (req_ch.data_in),
      .offset   (req_ch.offset),
      .length   (req_ch.length),
      .cmd      (cmd),
      .stat     (stat),
      .ok       (rsp_ch.ok),
      .data_out (rsp_ch.data_out),
      .has_data (rsp_ch.has_data),
      .count    (rsp_ch.count),
      .last     (rsp_ch.last)
   );

endmodule

[hw/rtl/brf_datapath.sv]
// Datapath of the byte ring FIFO: byte store, ring indices, size register
// and result register. Depends on brf_pkg; driven by brf_controller commands.

module brf_datapath import brf_pkg::*; #(
   parameter int MAX_DEPTH = DEF_MAX_DEPTH,
   parameter int MAX_SLICE = DEF_MAX_SLICE
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr,
   input  logic [SIZE_W-1:0]   csr_data,
   input  logic [DATA_W-1:0]   data_in,
   input  logic [OFFSET_W-1:0] offset,
   input  logic [LENGTH_W-1:0] length,
   input  brf_cmd_type         cmd,
   output brf_stat_type        stat,
   output logic                ok,
   output logic [DATA_W-1:0]   data_out,
   output logic                has_data,
   output logic [COUNT_W-1:0]  count,
   output logic                last
);

   // Ring uses the largest power of two not above MAX_DEPTH
   localparam int AW    = $clog2(MAX_DEPTH + 1) - 1;
   localparam int DEPTH = 2 ** AW;

   logic [DATA_W-1:0]   store_mem [DEPTH];
   logic [AW-1:0]       write_ff, write_in;
   logic [AW-1:0]       read_ff, read_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [SIZE_W-1:0]   size_ff;
   logic [DATA_W-1:0]   rd_data_ff;
   logic                ok_ff, has_ff, last_ff;
   logic [DATA_W-1:0]   data_ff;
   logic [COUNT_W-1:0]  count_ff;

   logic [SIZE_W-1:0]   size_eff;
   logic [AW-1:0]       mask;
   logic [AW-1:0]       held;
   logic [OFFSET_W-1:0] offset_eff;
   logic [AW-1:0]       rd_addr;
   logic [OFFSET_W:0]   span;

   // Clamp the size to the range the ring supports and build the index mask
   always_comb begin
      if (size_ff == '0) begin
         size_eff = SIZE_W'(1);
      end else if (size_ff > SIZE_W'(AW)) begin
         size_eff = SIZE_W'(AW);
      end else begin
         size_eff = size_ff;
      end
      mask = {AW{1'b1}} >> (SIZE_W'(AW) - size_eff);
   end

   // Occupancy and slice bounds check
   assign held = (write_ff - read_ff) & mask;
   assign span = {1'b0, offset} + (OFFSET_W + 1)'(length);

   assign stat.full     = (held == mask);
   assign stat.empty    = (held == '0);
   assign stat.slice_ok = (length <= LENGTH_W'(MAX_SLICE))
                       && (span <= (OFFSET_W + 1)'(held));

   // Read address: first byte of a get or slice, or the next slice byte
   assign offset_eff = cmd.use_offset ? offset : '0;
   assign rd_addr    = cmd.rd_first ? ((read_ff + AW'(offset_eff)) & mask)
                                    : ((pos_ff + AW'(1)) & mask);

   // Next index values
   always_comb begin
      write_in = write_ff;
      read_in  = read_ff;
      pos_in   = pos_ff;
      if (csr_wr || cmd.clear) begin
         write_in = '0;
         read_in  = '0;
      end else begin
         if (cmd.put) begin
            write_in = (write_ff + AW'(1)) & mask;
         end
         if (cmd.get) begin
            read_in = (read_ff + AW'(1)) & mask;
         end
      end
      if (cmd.rd_first || cmd.rd_next) begin
         pos_in = rd_addr;
      end
   end

   // Hold indices and size register
   always_ff @(posedge clock) begin
      if (reset) begin
         write_ff <= '0;
         read_ff  <= '0;
         pos_ff   <= '0;
         size_ff  <= SIZE_RESET;
      end else begin
         write_ff <= write_in;
         read_ff  <= read_in;
         pos_ff   <= pos_in;
         if (csr_wr) begin
            size_ff <= csr_data;
         end
      end
   end

   // Byte store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.put) begin
         store_mem[write_ff] <= data_in;
      end
      if (cmd.rd_first || cmd.rd_next) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ok_ff    <= cmd.ok;
         has_ff   <= cmd.has;
         last_ff  <= cmd.last;
         data_ff  <= cmd.has ? rd_data_ff : '0;
         count_ff <= COUNT_W'(held);
      end
   end

   assign ok       = ok_ff;
   assign has_data = has_ff;
   assign last     = last_ff;
   assign data_out = data_ff;
   assign count    = count_ff;

endmodule

[hw/rtl/brf_controller.sv]
// Controller of the byte ring FIFO: decodes each request, sequences slice
// reads and owns the result handshake. Depends on brf_pkg.

module brf_controller import brf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [LENGTH_W-1:0] req_length,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  brf_stat_type        stat,
   output brf_cmd_type         cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type           state_ff, state_in;
   logic [LENGTH_W-1:0] rem_ff, rem_in;
   logic                ok_ff, ok_in;
   logic                has_ff, has_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Decode requests and step through result transfers
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      rem_in   = rem_ff;
      ok_in    = ok_ff;
      has_in   = has_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EMIT;
               rem_in   = LENGTH_W'(1);
               ok_in    = 1'b0;
               has_in   = 1'b0;
               case (req_func)
                  FUNC_PUT: begin
                     cmd.put = !stat.full;
                     ok_in   = !stat.full;
                  end
                  FUNC_GET: begin
                     cmd.get      = !stat.empty;
                     cmd.rd_first = !stat.empty;
                     ok_in        = !stat.empty;
                     has_in       = !stat.empty;
                  end
                  FUNC_COUNT: begin
                     ok_in = 1'b1;
                  end
                  FUNC_CLEAR: begin
                     cmd.clear = 1'b1;
                     ok_in     = 1'b1;
                  end
                  FUNC_SLICE: begin
                     if (stat.slice_ok) begin
                        ok_in = 1'b1;
                        if (req_length != '0) begin
                           has_in         = 1'b1;
                           rem_in         = req_length;
                           cmd.rd_first   = 1'b1;
                           cmd.use_offset = 1'b1;
                        end
                     end
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.load = 1'b1;
               cmd.ok   = ok_ff;
               cmd.has  = has_ff;
               cmd.last = (rem_ff == LENGTH_W'(1));
               if (has_ff && (rem_ff != LENGTH_W'(1))) begin
                  cmd.rd_next = 1'b1;
                  rem_in      = rem_ff - LENGTH_W'(1);
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rem_ff       <= '0;
         ok_ff        <= 1'b0;
         has_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rem_ff       <= rem_in;
         ok_ff        <= ok_in;
         has_ff       <= has_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
